[design/rld_pkg.sv]
// ----------------------------------------------------------------------------
// rld_pkg
// Shared widths, register indexes, reset windows and queue entry type for the
// resistor ladder key decoder.
// ----------------------------------------------------------------------------
package rld_pkg;

    localparam int SAMPLE_BITS    = 10;
    localparam int WINDOW_BITS    = 2 * SAMPLE_BITS;
    localparam int CFG_INDEX_BITS = 3;
    localparam int KEY_COUNT      = 5;
    localparam int CODE_BITS      = 3;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODE_WINDOW        = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ARROW_UP_WINDOW    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ARROW_DOWN_WINDOW  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VOLUME_UP_WINDOW   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VOLUME_DOWN_WINDOW = 3'd4;

    // key positions, in event order
    localparam int KEY_MODE        = 0;
    localparam int KEY_VOLUME_UP   = 1;
    localparam int KEY_VOLUME_DOWN = 2;
    localparam int KEY_ARROW_UP    = 3;
    localparam int KEY_ARROW_DOWN  = 4;

    localparam logic [WINDOW_BITS-1:0] RST_MODE_WINDOW =
        WINDOW_BITS'((1023 << SAMPLE_BITS) | 1014);
    localparam logic [WINDOW_BITS-1:0] RST_ARROW_UP_WINDOW =
        WINDOW_BITS'((1023 << SAMPLE_BITS) | 1014);
    localparam logic [WINDOW_BITS-1:0] RST_ARROW_DOWN_WINDOW =
        WINDOW_BITS'((769 << SAMPLE_BITS) | 764);
    localparam logic [WINDOW_BITS-1:0] RST_VOLUME_UP_WINDOW =
        WINDOW_BITS'((511 << SAMPLE_BITS) | 503);
    localparam logic [WINDOW_BITS-1:0] RST_VOLUME_DOWN_WINDOW =
        WINDOW_BITS'((250 << SAMPLE_BITS) | 243);

    typedef logic [KEY_COUNT-1:0] key_mask_t;

    typedef struct packed {
        key_mask_t changed;
        key_mask_t keys;
    } scan_entry_t;

endpackage

[design/rld_front.sv]
// ----------------------------------------------------------------------------
// rld_front
// Accepts scans, holds the key windows, classifies both samples into a key
// mask and queues the changed keys of each scan.
// ----------------------------------------------------------------------------
module rld_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [rld_pkg::SAMPLE_BITS-1:0]    wheel_sample_a,
    input  logic [rld_pkg::SAMPLE_BITS-1:0]    wheel_sample_b,
    input  logic                               cfg_wr_en,
    input  logic [rld_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rld_pkg::WINDOW_BITS-1:0]    cfg_data,
    input  logic                               queue_full,
    output logic                               push,
    output rld_pkg::scan_entry_t               push_entry
);
    import rld_pkg::*;

    logic [WINDOW_BITS-1:0] mode_window_reg;
    logic [WINDOW_BITS-1:0] arrow_up_window_reg;
    logic [WINDOW_BITS-1:0] arrow_down_window_reg;
    logic [WINDOW_BITS-1:0] volume_up_window_reg;
    logic [WINDOW_BITS-1:0] volume_down_window_reg;
    key_mask_t              prev_keys_reg;
    key_mask_t              prev_keys_next;
    key_mask_t              keys;
    logic                   accept;
    logic                   hit_mode;
    logic                   hit_up;
    logic                   hit_down;
    logic                   hit_vup;
    logic                   hit_vdn;

    function automatic logic in_window(input logic [SAMPLE_BITS-1:0] sample,
                                       input logic [WINDOW_BITS-1:0] window);
        logic [SAMPLE_BITS-1:0] lo;
        logic [SAMPLE_BITS-1:0] hi;
        lo = window[SAMPLE_BITS-1:0];
        hi = window[WINDOW_BITS-1:SAMPLE_BITS];
        return (sample >= lo) && (sample <= hi);
    endfunction

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    assign hit_mode = in_window(wheel_sample_b, mode_window_reg);
    assign hit_vdn  = in_window(wheel_sample_a, volume_down_window_reg);
    assign hit_vup  = !hit_vdn && in_window(wheel_sample_a, volume_up_window_reg);
    assign hit_down = !hit_vdn && !hit_vup
                      && in_window(wheel_sample_a, arrow_down_window_reg);
    assign hit_up   = !hit_vdn && !hit_vup && !hit_down
                      && in_window(wheel_sample_a, arrow_up_window_reg);

    always_comb
    begin
        keys                  = '0;
        keys[KEY_MODE]        = hit_mode;
        keys[KEY_VOLUME_UP]   = hit_vup;
        keys[KEY_VOLUME_DOWN] = hit_vdn;
        keys[KEY_ARROW_UP]    = hit_up;
        keys[KEY_ARROW_DOWN]  = hit_down;
    end

    assign push_entry.changed = keys ^ prev_keys_reg;
    assign push_entry.keys    = keys;
    assign push               = accept && (push_entry.changed != '0);
    assign prev_keys_next     = accept ? keys : prev_keys_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_keys_reg <= '0;
        end
        else
        begin
            prev_keys_reg <= prev_keys_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_window_reg        <= RST_MODE_WINDOW;
            arrow_up_window_reg    <= RST_ARROW_UP_WINDOW;
            arrow_down_window_reg  <= RST_ARROW_DOWN_WINDOW;
            volume_up_window_reg   <= RST_VOLUME_UP_WINDOW;
            volume_down_window_reg <= RST_VOLUME_DOWN_WINDOW;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MODE_WINDOW:        mode_window_reg        <= cfg_data;
                REG_ARROW_UP_WINDOW:    arrow_up_window_reg    <= cfg_data;
                REG_ARROW_DOWN_WINDOW:  arrow_down_window_reg  <= cfg_data;
                REG_VOLUME_UP_WINDOW:   volume_up_window_reg   <= cfg_data;
                REG_VOLUME_DOWN_WINDOW: volume_down_window_reg <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

[design/rld_queue.sv]
// ----------------------------------------------------------------------------
// rld_queue
// Short first-in first-out queue of classified scans between the front and
// the event generator.
// ----------------------------------------------------------------------------
module rld_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rld_pkg::scan_entry_t push_entry,
    input  logic                 pop,
    output rld_pkg::scan_entry_t head_entry,
    output logic                 full,
    output logic                 empty
);
    import rld_pkg::*;

    scan_entry_t               slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_BITS-1:0] count_reg;
    logic [QUEUE_CNT_BITS-1:0] count_next;

    assign full       = (count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign empty      = (count_reg == '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");

endmodule

[design/rld_back.sv]
// ----------------------------------------------------------------------------
// rld_back
// Takes queued scans and emits one press or release event per cycle while
// out_stall is low, in key order, through an output register; marks the last
// event of each scan.
module rld_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rld_pkg::scan_entry_t          head_entry,
    input  logic                          empty,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rld_pkg::CODE_BITS-1:0] button_code,
    output logic                          pressed,
    output logic                          last_event
);
    import rld_pkg::*;

    key_mask_t              pend_reg;
    key_mask_t              pend_next;
    key_mask_t              keys_reg;
    key_mask_t              keys_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [CODE_BITS-1:0]   code_reg;
    logic                   pressed_reg;
    logic                   last_reg;
    logic                   out_free;
    logic                   have_work;
    key_mask_t              src_mask;
    key_mask_t              src_keys;
    key_mask_t              remaining;
    logic [CODE_BITS-1:0]   sel;

    assign out_free  = !out_valid_reg || !out_stall;
    assign have_work = (pend_reg != '0) || !empty;
    assign pop       = out_free && (pend_reg == '0) && !empty;
    assign src_mask  = (pend_reg != '0) ? pend_reg : head_entry.changed;
    assign src_keys  = (pend_reg != '0) ? keys_reg : head_entry.keys;

    always_comb
    begin
        sel = '0;
        for (int k = KEY_COUNT - 1; k >= 0; k--)
        begin
            if (src_mask[k])
            begin
                sel = CODE_BITS'(k);
            end
        end
    end

    assign remaining = src_mask & ~(KEY_COUNT'(1) << sel);

    always_comb
    begin
        pend_next      = pend_reg;
        keys_next      = keys_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (out_free && have_work)
        begin
            pend_next      = remaining;
            keys_next      = src_keys;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        keys_reg <= keys_next;
        if (out_free && have_work)
        begin
            code_reg    <= sel;
            pressed_reg <= src_keys[sel];
            last_reg    <= (remaining == '0);
        end
    end

    assign out_valid   = out_valid_reg;
    assign button_code = code_reg;
    assign pressed     = pressed_reg;
    assign last_event  = last_reg;

    a_pending_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg != '0) |-> out_valid_reg)
        else $error("events pending without a shown transaction");

    a_not_last_has_more: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> (pend_reg != '0))
        else $error("event not marked last but nothing pending");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (code_reg <= CODE_BITS'(KEY_COUNT - 1)))
        else $error("button code out of range");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (pend_reg == '0))
        else $error("scan taken while previous scan still pending");

endmodule

[design/resistor_ladder_key_decoder.sv]
// ----------------------------------------------------------------------------
// resistor_ladder_key_decoder
// Steering-wheel key decoder: classifies two ladder samples per scan into a
// five-key mask and emits a press or release transaction per changed key.
// ----------------------------------------------------------------------------
// A scan is taken whenever the four-entry scan queue has room; its window
// compares and the change mask are worked out in the cycle it is taken. The
// event generator then sends one transaction per changed key, one per cycle
// while out_stall is low, in the order mode, volume up, volume down, arrow
// up, arrow down, the last marked by last_event; a scan with no change sends
// nothing. The sustained rate is set by the single output register. The
// first event of a scan is registered in a queue slot and then in the output
// register. Window registers are written through cfg_wr_en, cfg_index and
// cfg_data; an unknown index is ignored.
module resistor_ladder_key_decoder (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [rld_pkg::SAMPLE_BITS-1:0]    wheel_sample_a,
    input  logic [rld_pkg::SAMPLE_BITS-1:0]    wheel_sample_b,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [rld_pkg::CODE_BITS-1:0]      button_code,
    output logic                               pressed,
    output logic                               last_event,
    input  logic                               cfg_wr_en,
    input  logic [rld_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rld_pkg::WINDOW_BITS-1:0]    cfg_data
);
    import rld_pkg::*;

    logic        push;
    logic        pop;
    logic        queue_full;
    logic        queue_empty;
    scan_entry_t push_entry;
    scan_entry_t head_entry;

    rld_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .wheel_sample_a (wheel_sample_a),
        .wheel_sample_b (wheel_sample_b),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .queue_full     (queue_full),
        .push           (push),
        .push_entry     (push_entry)
    );

    rld_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .full       (queue_full),
        .empty      (queue_empty)
    );

    rld_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_entry  (head_entry),
        .empty       (queue_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .button_code (button_code),
        .pressed     (pressed),
        .last_event  (last_event)
    );

endmodule

[tb/sv/key_event_check_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_event_check_pkg
// Key mask tracking and event checking for the resistor ladder key decoder.
// Each accepted scan is classified against the current windows, compared with
// the held mask, and turned into expected press and release transactions that
// the output side checks in order.
// ----------------------------------------------------------------------------
package key_event_check_pkg;

    import rld_pkg::*;

    typedef struct packed {
        logic [CODE_BITS-1:0] code;
        logic                 pressed;
        logic                 closes_scan;
    } key_event_t;

    class key_event_tracker;

        logic [WINDOW_BITS-1:0] windows [KEY_COUNT];
        key_mask_t              held_keys;
        key_event_t             pending_events [$];
        int                     mismatches;
        int                     events_seen;

        function new();
            windows[REG_MODE_WINDOW]        = RST_MODE_WINDOW;
            windows[REG_ARROW_UP_WINDOW]    = RST_ARROW_UP_WINDOW;
            windows[REG_ARROW_DOWN_WINDOW]  = RST_ARROW_DOWN_WINDOW;
            windows[REG_VOLUME_UP_WINDOW]   = RST_VOLUME_UP_WINDOW;
            windows[REG_VOLUME_DOWN_WINDOW] = RST_VOLUME_DOWN_WINDOW;
            held_keys   = '0;
            mismatches  = 0;
            events_seen = 0;
        endfunction

        function bit hits(logic [SAMPLE_BITS-1:0] sample, logic [WINDOW_BITS-1:0] win);
            return sample >= win[SAMPLE_BITS-1:0] && sample <= win[WINDOW_BITS-1:SAMPLE_BITS];
        endfunction

        function void write_window(logic [CFG_INDEX_BITS-1:0] idx,
                                   logic [WINDOW_BITS-1:0] value);
            if (idx <= REG_VOLUME_DOWN_WINDOW)
                windows[idx] = value;
        endfunction

        function void take_scan(logic [SAMPLE_BITS-1:0] sample_a,
                                logic [SAMPLE_BITS-1:0] sample_b);
            key_mask_t  keys;
            key_mask_t  flips;
            key_event_t ev;
            int         last_key;
            keys = '0;
            if (hits(sample_b, windows[REG_MODE_WINDOW]))
                keys[KEY_MODE] = 1'b1;
            // one channel A key only; volume down has the highest priority
            if (hits(sample_a, windows[REG_VOLUME_DOWN_WINDOW]))
                keys[KEY_VOLUME_DOWN] = 1'b1;
            else if (hits(sample_a, windows[REG_VOLUME_UP_WINDOW]))
                keys[KEY_VOLUME_UP] = 1'b1;
            else if (hits(sample_a, windows[REG_ARROW_DOWN_WINDOW]))
                keys[KEY_ARROW_DOWN] = 1'b1;
            else if (hits(sample_a, windows[REG_ARROW_UP_WINDOW]))
                keys[KEY_ARROW_UP] = 1'b1;
            flips    = keys ^ held_keys;
            last_key = -1;
            for (int k = 0; k < KEY_COUNT; k++)
                if (flips[k])
                    last_key = k;
            for (int k = 0; k < KEY_COUNT; k++) begin
                if (flips[k]) begin
                    ev.code        = CODE_BITS'(k);
                    ev.pressed     = keys[k];
                    ev.closes_scan = (k == last_key);
                    pending_events.push_back(ev);
                end
            end
            held_keys = keys;
        endfunction

        function void check_event(logic [CODE_BITS-1:0] code, logic pressed,
                                  logic closes_scan);
            key_event_t want;
            events_seen++;
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected transaction code %0d pressed %0b last_event %0b",
                         $time, code, pressed, closes_scan);
                mismatches++;
                return;
            end
            want = pending_events.pop_front();
            if (code !== want.code) begin
                $display("%0t: button_code expected %0d, actual %0d", $time, want.code, code);
                mismatches++;
            end
            if (pressed !== want.pressed) begin
                $display("%0t: pressed expected %0b, actual %0b", $time, want.pressed, pressed);
                mismatches++;
            end
            if (closes_scan !== want.closes_scan) begin
                $display("%0t: last_event expected %0b, actual %0b",
                         $time, want.closes_scan, closes_scan);
                mismatches++;
            end
        endfunction

    endclass

endpackage

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the resistor ladder key decoder. Directed scans probe the
// window edges, key priority, empty and single-point windows; random phases
// write the ignored register indexes and send scans aimed at the windows.
// Bursty input and patterned output stalls exercise both handshakes.
// ----------------------------------------------------------------------------
module tb;

    import rld_pkg::*;
    import key_event_check_pkg::*;

    localparam int SAMPLE_MAX       = (1 << SAMPLE_BITS) - 1;
    localparam int SETTLE_CYCLES    = 30;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int RANDOM_PHASES    = 5;
    localparam int ITEMS_PER_PHASE  = 22;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_UNUSED = REG_VOLUME_DOWN_WINDOW + 1'b1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LAST_UNUSED  = '1;
    localparam logic [WINDOW_BITS-1:0] WINDOW_FULL  = {SAMPLE_BITS'(SAMPLE_MAX), SAMPLE_BITS'(0)};
    localparam logic [WINDOW_BITS-1:0] WINDOW_EMPTY = {SAMPLE_BITS'(0), SAMPLE_BITS'(SAMPLE_MAX)};
    localparam logic [WINDOW_BITS-1:0] WINDOW_ZERO  = '0;
    localparam logic [WINDOW_BITS-1:0] WINDOW_TOP   = '1;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_style_t;

    logic                      clk            = 1'b0;
    logic                      rst_n          = 1'b0;
    logic                      in_valid       = 1'b0;
    logic                      in_stall;
    logic [SAMPLE_BITS-1:0]    wheel_sample_a = '0;
    logic [SAMPLE_BITS-1:0]    wheel_sample_b = '0;
    logic                      out_valid;
    logic                      out_stall      = 1'b0;
    logic [CODE_BITS-1:0]      button_code;
    logic                      pressed;
    logic                      last_event;
    logic                      cfg_wr_en      = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index      = '0;
    logic [WINDOW_BITS-1:0]    cfg_data       = '0;

    key_event_tracker tracker = new();

    stall_style_t           stall_style = STALL_NONE;
    int                     stall_cycle = 0;
    int                     burst_left  = 0;
    int                     scans_sent  = 0;
    int                     settings    = 1;
    logic [SAMPLE_BITS-1:0] prev_a      = '0;
    logic [SAMPLE_BITS-1:0] prev_b      = '0;

    resistor_ladder_key_decoder u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .wheel_sample_a (wheel_sample_a),
        .wheel_sample_b (wheel_sample_b),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .button_code    (button_code),
        .pressed        (pressed),
        .last_event     (last_event),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        if (stall_cycle == 0)
        begin
            stall_style <= stall_style_t'($urandom_range(STALL_NONE, STALL_TOGGLE));
            stall_cycle <= $urandom_range(20, 80);
        end
        else
        begin
            stall_cycle <= stall_cycle - 1;
        end
        case (stall_style)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= ~out_stall;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_event(button_code, pressed, last_event);
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("resistor_ladder_key_decoder: mismatch");
        $finish;
    end

    task automatic send_scan(input logic [SAMPLE_BITS-1:0] a, input logic [SAMPLE_BITS-1:0] b);
        int gap;
        in_valid       <= 1'b1;
        wheel_sample_a <= a;
        wheel_sample_b <= b;
        do
            @(posedge clk);
        while (in_stall);
        tracker.take_scan(a, b);
        scans_sent++;
        prev_a = a;
        prev_b = b;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        else
        begin
            burst_left--;
        end
    endtask

    // hold off until every expected transaction is out and the queue is empty
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.pending_events.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_window(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [WINDOW_BITS-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        tracker.write_window(idx, value);
    endtask

    task automatic set_windows(input logic [WINDOW_BITS-1:0] mode_w,
                               input logic [WINDOW_BITS-1:0] up_w,
                               input logic [WINDOW_BITS-1:0] down_w,
                               input logic [WINDOW_BITS-1:0] vup_w,
                               input logic [WINDOW_BITS-1:0] vdn_w);
        write_window(REG_MODE_WINDOW, mode_w);
        write_window(REG_ARROW_UP_WINDOW, up_w);
        write_window(REG_ARROW_DOWN_WINDOW, down_w);
        write_window(REG_VOLUME_UP_WINDOW, vup_w);
        write_window(REG_VOLUME_DOWN_WINDOW, vdn_w);
        cfg_wr_en <= 1'b0;
        settings++;
    endtask

    function automatic logic [WINDOW_BITS-1:0] random_window();
        int lo;
        int hi;
        lo = $urandom_range(0, SAMPLE_MAX);
        hi = lo + int'($urandom_range(0, 200));
        if (hi > SAMPLE_MAX)
            hi = SAMPLE_MAX;
        if ($urandom_range(0, 9) == 0)
            hi = $urandom_range(0, SAMPLE_MAX);
        return {SAMPLE_BITS'(hi), SAMPLE_BITS'(lo)};
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] aim_at(logic [WINDOW_BITS-1:0] win);
        int lo;
        int hi;
        int pick;
        lo = int'(win[SAMPLE_BITS-1:0]);
        hi = int'(win[WINDOW_BITS-1:SAMPLE_BITS]);
        case ($urandom_range(0, 9))
            0, 1:    pick = lo + int'($urandom_range(0, 2)) - 1;
            2, 3:    pick = hi + int'($urandom_range(0, 2)) - 1;
            default: pick = (lo <= hi) ? int'($urandom_range(lo, hi))
                                       : int'($urandom_range(0, SAMPLE_MAX));
        endcase
        if (pick < 0)
            pick = 0;
        if (pick > SAMPLE_MAX)
            pick = SAMPLE_MAX;
        return SAMPLE_BITS'(pick);
    endfunction

    task automatic send_random_scan();
        logic [SAMPLE_BITS-1:0] a;
        logic [SAMPLE_BITS-1:0] b;
        int                     roll;
        roll = $urandom_range(0, 9);
        if (roll < 2)
            a = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
        else if (roll < 4)
            a = prev_a;
        else
            a = aim_at(tracker.windows[$urandom_range(REG_ARROW_UP_WINDOW,
                                                      REG_VOLUME_DOWN_WINDOW)]);
        roll = $urandom_range(0, 9);
        if (roll < 3)
            b = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
        else if (roll < 5)
            b = prev_b;
        else
            b = aim_at(tracker.windows[REG_MODE_WINDOW]);
        send_scan(a, b);
    endtask

    task automatic run_directed();
        logic [SAMPLE_BITS-1:0] probe_a [14] = '{0, 1023, 0, 243, 250, 251, 242,
                                                 503, 511, 764, 769, 770, 1014, 1013};
        logic [SAMPLE_BITS-1:0] probe_b [14] = '{0, 1023, 0, 0, 1014, 1013, 0,
                                                 1014, 1013, 1023, 0, 0, 1014, 1013};
        for (int i = 0; i < 14; i++)
            send_scan(probe_a[i], probe_b[i]);

        // overlapping windows: drop the winner one at a time
        settle();
        set_windows(WINDOW_FULL, WINDOW_FULL, WINDOW_FULL, WINDOW_FULL, WINDOW_FULL);
        send_scan(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)),
                  SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
        settle();
        write_window(REG_VOLUME_DOWN_WINDOW, WINDOW_EMPTY);
        cfg_wr_en <= 1'b0;
        send_scan(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)), 0);
        settle();
        write_window(REG_VOLUME_UP_WINDOW, WINDOW_EMPTY);
        cfg_wr_en <= 1'b0;
        send_scan(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)), SAMPLE_BITS'(SAMPLE_MAX));
        settle();
        write_window(REG_ARROW_DOWN_WINDOW, WINDOW_EMPTY);
        cfg_wr_en <= 1'b0;
        send_scan(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)), 0);
        settle();
        write_window(REG_ARROW_UP_WINDOW, WINDOW_EMPTY);
        cfg_wr_en <= 1'b0;
        send_scan(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)), SAMPLE_BITS'(SAMPLE_MAX));

        // single-point windows at both ends of the range
        settle();
        set_windows(WINDOW_ZERO, WINDOW_ZERO, WINDOW_ZERO, WINDOW_ZERO, WINDOW_ZERO);
        send_scan(0, 0);
        send_scan(1, 1);
        settle();
        set_windows(WINDOW_TOP, WINDOW_TOP, WINDOW_TOP, WINDOW_TOP, WINDOW_TOP);
        send_scan(SAMPLE_BITS'(SAMPLE_MAX), SAMPLE_BITS'(SAMPLE_MAX));
        send_scan(SAMPLE_BITS'(SAMPLE_MAX - 1), 0);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            // unused indexes must leave every window alone
            for (int idx = REG_FIRST_UNUSED; idx <= REG_LAST_UNUSED; idx++)
                write_window(CFG_INDEX_BITS'(idx), WINDOW_BITS'($urandom()));
            if (p == 0)
                set_windows(RST_MODE_WINDOW, RST_ARROW_UP_WINDOW, RST_ARROW_DOWN_WINDOW,
                            RST_VOLUME_UP_WINDOW, RST_VOLUME_DOWN_WINDOW);
            else
                set_windows(random_window(), random_window(), random_window(),
                            random_window(), random_window());
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_random_scan();
        end

        in_valid <= 1'b0;
        while (tracker.pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d scans and %0d key transactions over %0d window settings.",
                 scans_sent, tracker.events_seen, settings);
        if (tracker.mismatches == 0 && tracker.pending_events.size() == 0)
            $display("resistor_ladder_key_decoder: match");
        else
            $display("resistor_ladder_key_decoder: mismatch");
        $finish;
    end

endmodule

[filelist.f]
design/rld_pkg.sv
design/rld_front.sv
design/rld_queue.sv
design/rld_back.sv
design/resistor_ladder_key_decoder.sv
tb/sv/key_event_check_pkg.sv
tb/sv/tb.sv
